// ===== design/mdb_pkg.sv =====
// Shared types, constants and the rounding/saturation helper for the masked
// depth back-projection block. Used by mdb_ctrl, mdb_dp and the top level.
// Depends on nothing.
package mdb_pkg;

    // Fixed field widths of the projection arithmetic.
    localparam int POS_W   = 12;
    localparam int MAG_W   = 16;
    localparam int DEPTH_W = 24;
    localparam int INV_W   = 24;
    localparam int PD_W    = 40;
    localparam int HALF_W  = 20;
    localparam int OPA_W   = 24;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 64;
    localparam int COORD_W = 32;
    localparam int CNT_W   = 25;
    localparam int DIM_CFG_W = 13;

    // Configuration register indexes.
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_WIDTH       = 3'd0;
    localparam t_reg_idx REG_HEIGHT      = 3'd1;
    localparam t_reg_idx REG_CENTER_X    = 3'd2;
    localparam t_reg_idx REG_CENTER_Y    = 3'd3;
    localparam t_reg_idx REG_INV_FOCAL_X = 3'd4;
    localparam t_reg_idx REG_INV_FOCAL_Y = 3'd5;
    localparam t_reg_idx REG_MIN_DEPTH   = 3'd6;

    // Multiply sequence steps, one product per step on the shared multiplier.
    typedef logic [2:0] t_step;
    localparam t_step STEP_X_DEPTH = 3'd0;
    localparam t_step STEP_X_LO    = 3'd1;
    localparam t_step STEP_X_HI    = 3'd2;
    localparam t_step STEP_Y_DEPTH = 3'd3;
    localparam t_step STEP_Y_LO    = 3'd4;
    localparam t_step STEP_Y_HI    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  step_en;
        t_step step;
        logic  load_out;
    } t_cmd;

    // Round a Q.44 magnitude to Q.16 (ties away from zero), apply the sign and
    // saturate to a signed 32-bit value.
    function automatic logic [COORD_W-1:0] round_sat(input logic [ACC_W-1:0] acc,
                                                     input logic neg);
        logic [ACC_W:0]   sum;
        logic [ACC_W-28:0] mag;
        logic [COORD_W-1:0] res;
        begin
            sum = {1'b0, acc} + 65'h0_0000_0000_0800_0000;
            mag = sum[ACC_W:28];
            if (neg) begin
                if (mag >= 37'h0_8000_0000) begin
                    res = 32'h8000_0000;
                end else begin
                    res = 32'h0 - mag[COORD_W-1:0];
                end
            end else begin
                if (mag > 37'h0_7FFF_FFFF) begin
                    res = 32'h7FFF_FFFF;
                end else begin
                    res = mag[COORD_W-1:0];
                end
            end
            return res;
        end
    endfunction

endpackage

// ===== design/masked_depth_backprojection.sv =====
// Top level of the masked depth back-projection block.
// Depends on mdb_pkg, mdb_ctrl and mdb_dp.
//
// Pixels are taken in raster order, one request per handshake, and each gives
// exactly one result carrying the point flag, X/Y in signed Q16.16 and Z in
// Q8.16 metres, the frame end mark and the running point count of the frame.
// A request occupies the block until the next acceptance: multiply steps on
// a single shared 24x24 multiplier (offset times depth, then that product
// times the reciprocal focal length in two halves, for X and for Y) and a
// final state to round, saturate and load the result register. The result
// appears the cycle after that and may wait there under stall while the next
// request is already being accepted and computed. Configuration writes must
// only be issued while no request is in flight.
module masked_depth_backprojection
    import mdb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [23:0]               i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_mask_value,
    input  logic [DEPTH_W-1:0]        i_depth_value,
    input  logic                      i_depth_invalid,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_point_valid,
    output logic signed [COORD_W-1:0] o_point_x,
    output logic signed [COORD_W-1:0] o_point_y,
    output logic [DEPTH_W-1:0]        o_point_z,
    output logic                      o_frame_end,
    output logic [CNT_W-1:0]          o_points_so_far
);

    t_cmd cmd;

    // Sequencer and handshake control.
    mdb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Counters, arithmetic and result register.
    mdb_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mask_value    (i_mask_value),
        .i_depth_value   (i_depth_value),
        .i_depth_invalid (i_depth_invalid),
        .o_point_valid   (o_point_valid),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_point_z       (o_point_z),
        .o_frame_end     (o_frame_end),
        .o_points_so_far (o_points_so_far)
    );

endmodule

// ===== design/mdb_ctrl.sv =====
// Controller of the masked depth back-projection block: request handshake,
// multiply step sequencing and the output register's full flag.
// Depends on mdb_pkg.
module mdb_ctrl
    import mdb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    output logic o_stall,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    t_step      r_step, n_step;
    logic       r_out_full, n_out_full;
    t_cmd       cmd;
    logic       out_take;

    // Next-state logic and command decode.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        cmd          = '0;
        cmd.step     = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = ST_CALC;
                    n_step     = STEP_X_DEPTH;
                end
            end
            ST_CALC: begin
                cmd.step_en = 1'b1;
                if (r_step == STEP_Y_HI) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DONE: begin
                // The result register frees up when empty or taken this cycle.
                if (!r_out_full || !i_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    assign out_take = r_out_full && !i_stall;

    always_comb begin
        if (cmd.load_out) begin
            n_out_full = 1'b1;
        end else if (out_take) begin
            n_out_full = 1'b0;
        end else begin
            n_out_full = r_out_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= STEP_X_DEPTH;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_out_full <= n_out_full;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_full;
    assign o_cmd   = cmd;

`ifndef SYNTHESIS
    // An accepted request always starts the multiply sequence at its first step.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> (r_state == ST_CALC && r_step == STEP_X_DEPTH))
        else $error("accepted request did not start the multiply sequence");

    // Loading the result register always leaves it holding a result.
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> r_out_full)
        else $error("result register empty after a load");

    // A waiting result is never overwritten while the consumer stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_full && i_stall) |-> !cmd.load_out)
        else $error("result register overwritten while stalled");

    // The step counter never runs past the last multiply step while computing.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_step <= STEP_Y_HI))
        else $error("multiply step out of range");
`endif

endmodule

// ===== design/mdb_dp.sv =====
// Datapath of the masked depth back-projection block: configuration registers,
// raster counters, shared multiplier with accumulator and the result register.
// Depends on mdb_pkg.
module mdb_dp
    import mdb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [23:0]               i_cfg_data,
    input  logic [7:0]                i_mask_value,
    input  logic [DEPTH_W-1:0]        i_depth_value,
    input  logic                      i_depth_invalid,
    output logic                      o_point_valid,
    output logic signed [COORD_W-1:0] o_point_x,
    output logic signed [COORD_W-1:0] o_point_y,
    output logic [DEPTH_W-1:0]        o_point_z,
    output logic                      o_frame_end,
    output logic [CNT_W-1:0]          o_points_so_far
);

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam logic [DIM_CFG_W-1:0] DIM_MAX = DIM_CFG_W'(MAX_DIM);
    localparam logic [CNT_W-1:0]     CNT_MAX = {CNT_W{1'b1}};

    // Configuration registers.
    logic [DIM_CFG_W-1:0] r_width, r_height;
    logic [MAG_W-1:0]     r_cx, r_cy;
    logic [INV_W-1:0]     r_invx, r_invy;
    logic [DEPTH_W-1:0]   r_min_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 13'd640;
            r_height    <= 13'd480;
            r_cx        <= 16'd5069;
            r_cy        <= 16'd3817;
            r_invx      <= 24'd54163;
            r_invy      <= 24'd40832;
            r_min_depth <= 24'd6554;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:       r_width     <= i_cfg_data[DIM_CFG_W-1:0];
                REG_HEIGHT:      r_height    <= i_cfg_data[DIM_CFG_W-1:0];
                REG_CENTER_X:    r_cx        <= i_cfg_data[MAG_W-1:0];
                REG_CENTER_Y:    r_cy        <= i_cfg_data[MAG_W-1:0];
                REG_INV_FOCAL_X: r_invx      <= i_cfg_data;
                REG_INV_FOCAL_Y: r_invy      <= i_cfg_data;
                REG_MIN_DEPTH:   r_min_depth <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize acts as the maximum.
    logic [DIM_CFG_W-1:0] w_eff, h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_CFG_W'(1);
        end else if (r_width > DIM_MAX) begin
            w_eff = DIM_MAX;
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_CFG_W'(1);
        end else if (r_height > DIM_MAX) begin
            h_eff = DIM_MAX;
        end else begin
            h_eff = r_height;
        end
    end

    // Raster position and frame point count.
    logic [DIM_W-1:0] r_col, r_row;
    logic [CNT_W-1:0] r_points;
    logic             row_end, frame_end, sel;
    logic [CNT_W-1:0] n_item_cnt;
    logic [MAG_W-1:0] p16x, p16y;

    assign row_end   = DIM_CFG_W'(r_col) >= (w_eff - DIM_CFG_W'(1));
    assign frame_end = row_end && (DIM_CFG_W'(r_row) >= (h_eff - DIM_CFG_W'(1)));
    assign sel       = (i_mask_value != 8'd0) && !i_depth_invalid &&
                       (i_depth_value > r_min_depth);
    assign n_item_cnt = (sel && r_points != CNT_MAX) ? r_points + CNT_W'(1) : r_points;
    assign p16x = {POS_W'(r_col), 4'b0000};
    assign p16y = {POS_W'(r_row), 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_points <= '0;
        end else if (i_cmd.accept) begin
            if (frame_end) begin
                r_col    <= '0;
                r_row    <= '0;
                r_points <= '0;
            end else begin
                r_points <= n_item_cnt;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + DIM_W'(1);
                end else begin
                    r_col <= r_col + DIM_W'(1);
                end
            end
        end
    end

    // Per-request operands captured at acceptance.
    logic [DEPTH_W-1:0] r_depth;
    logic               r_sel, r_fend, r_negx, r_negy;
    logic [MAG_W-1:0]   r_magx, r_magy;
    logic [CNT_W-1:0]   r_item_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_depth    <= i_depth_value;
            r_sel      <= sel;
            r_fend     <= frame_end;
            r_item_cnt <= n_item_cnt;
            r_negx     <= p16x < r_cx;
            r_magx     <= (p16x < r_cx) ? r_cx - p16x : p16x - r_cx;
            r_negy     <= p16y < r_cy;
            r_magy     <= (p16y < r_cy) ? r_cy - p16y : p16y - r_cy;
        end
    end

    // Shared 24x24 multiplier: offset*depth, then that product times the
    // reciprocal focal length in two 20-bit halves.
    logic [OPA_W-1:0]  op_a;
    logic [INV_W-1:0]  op_b;
    logic [PROD_W-1:0] prod;
    logic [PD_W-1:0]   r_pd;
    logic [ACC_W-1:0]  r_acc;
    logic [COORD_W-1:0] r_px;

    always_comb begin
        case (i_cmd.step)
            STEP_X_DEPTH: begin
                op_a = OPA_W'(r_magx);
                op_b = r_depth;
            end
            STEP_X_LO: begin
                op_a = OPA_W'(r_pd[HALF_W-1:0]);
                op_b = r_invx;
            end
            STEP_X_HI: begin
                op_a = OPA_W'(r_pd[PD_W-1:HALF_W]);
                op_b = r_invx;
            end
            STEP_Y_DEPTH: begin
                op_a = OPA_W'(r_magy);
                op_b = r_depth;
            end
            STEP_Y_LO: begin
                op_a = OPA_W'(r_pd[HALF_W-1:0]);
                op_b = r_invy;
            end
            STEP_Y_HI: begin
                op_a = OPA_W'(r_pd[PD_W-1:HALF_W]);
                op_b = r_invy;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_en) begin
            case (i_cmd.step)
                STEP_X_DEPTH: begin
                    r_pd <= prod[PD_W-1:0];
                end
                STEP_Y_DEPTH: begin
                    r_pd <= prod[PD_W-1:0];
                    r_px <= round_sat(r_acc, r_negx);
                end
                STEP_X_LO, STEP_Y_LO: begin
                    r_acc <= ACC_W'(prod);
                end
                STEP_X_HI, STEP_Y_HI: begin
                    r_acc <= r_acc + ACC_W'({prod, {HALF_W{1'b0}}});
                end
                default: begin
                end
            endcase
        end
    end

    // Result register; a rejected pixel shows zero coordinates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_point_valid   <= r_sel;
            o_point_x       <= r_sel ? r_px : '0;
            o_point_y       <= r_sel ? round_sat(r_acc, r_negy) : '0;
            o_point_z       <= r_sel ? r_depth : '0;
            o_frame_end     <= r_fend;
            o_points_so_far <= r_item_cnt;
        end
    end

endmodule
